### src/shared_double_stack_assert.svh
// Assertion macros shared by the files of the double stack.
`ifndef SHARED_DOUBLE_STACK_ASSERT_SVH
`define SHARED_DOUBLE_STACK_ASSERT_SVH

`ifndef SYNTHESIS
// Checks that a property holds at every rising clock edge outside reset.
`define SDS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checks that a condition never comes true outside reset.
`define SDS_ASSERT_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define SDS_ASSERT(name, prop, msg)
`define SDS_ASSERT_NEVER(name, cond, msg)
`endif

`endif

### src/sdstk_pkg.sv
package sdstk_pkg;

   // Storage geometry.
   localparam int DEPTH  = 32;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Field widths of the items.
   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 6;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
      logic deliver;
   } cmd_type;

endpackage

### src/sdstk_req_if.sv
interface sdstk_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [sdstk_pkg::FUNC_W-1:0]           func;
   logic                                   stack_sel;
   logic signed [sdstk_pkg::DATA_W-1:0]    push_value;

   modport source (output valid, output func, output stack_sel, output push_value,
                   input ready);
   modport sink (input valid, input func, input stack_sel, input push_value,
                 output ready);
endinterface

### src/sdstk_rsp_if.sv
interface sdstk_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [sdstk_pkg::DATA_W-1:0]    pop_value;
   logic [sdstk_pkg::STATUS_W-1:0]         status;
   logic [sdstk_pkg::TOTAL_W-1:0]          total_length;
   logic                                   all_empty;

   modport source (output valid, output pop_value, output status, output total_length,
                   output all_empty, input ready);
   modport sink (input valid, input pop_value, input status, input total_length,
                 input all_empty, output ready);
endinterface

### src/shared_double_stack.sv
// Two LIFO stacks kept in one memory: stack 0 grows up from the bottom entry,
// stack 1 grows down from the top entry.
// The request channel carries one operation per item: push, pop or clear,
// the selected stack and the value to push. The response channel returns one
// item per request with the popped value, a status, the total element count
// and an all-empty flag, all taken after the operation.
// A request is captured in state IDLE, the memory access happens in state EXEC,
// and the result is loaded into the output register in state LOAD once that
// register is free; the response is valid once the result has been loaded.
// The block takes no new request until the previous one has left state LOAD,
// since the controller accepts a request only in state IDLE.
// A result may wait in the output register while the next request is taken;
// if the receiver still holds off when that next result is ready, the block
// waits and takes no further request.
// Reset clears both stack counts and the handshake state; the memory itself
// is not cleared and holds no valid data until written.
`include "shared_double_stack_assert.svh"

module shared_double_stack (
   input logic         clock,
   input logic         reset,
   sdstk_req_if.sink   req_ch,
   sdstk_rsp_if.source rsp_ch
);

   sdstk_pkg::cmd_type cmd;

   // Control.
   sdstk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // Storage, counts and result register.
   sdstk_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .func         (req_ch.func),
      .stack_sel    (req_ch.stack_sel),
      .push_value   (req_ch.push_value),
      .pop_value    (rsp_ch.pop_value),
      .status       (rsp_ch.status),
      .total_length (rsp_ch.total_length),
      .all_empty    (rsp_ch.all_empty)
   );

   // Only one item is in flight between capture and result load.
   `SDS_ASSERT(a_one_in_flight, (req_ch.valid && req_ch.ready) |=> !req_ch.ready, "item accepted while busy")
   // A response appears only after the datapath loaded a result.
   `SDS_ASSERT(a_rsp_after_load, $rose(rsp_ch.valid) |-> $past(cmd.deliver), "response without result load")
   // The two stacks never hold more than the memory depth.
   `SDS_ASSERT_NEVER(a_no_overflow, rsp_ch.valid && (rsp_ch.total_length > sdstk_pkg::TOTAL_W'(sdstk_pkg::DEPTH)), "element count above depth")
   // The all-empty flag agrees with the element count.
   `SDS_ASSERT(a_empty_flag, rsp_ch.valid |-> (rsp_ch.all_empty == (rsp_ch.total_length == '0)), "all-empty flag disagrees with count")

endmodule

### src/sdstk_ram.sv
module sdstk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single port: one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/sdstk_datapath.sv
module sdstk_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sdstk_pkg::cmd_type                   cmd,
   input  logic [sdstk_pkg::FUNC_W-1:0]         func,
   input  logic                                 stack_sel,
   input  logic signed [sdstk_pkg::DATA_W-1:0]  push_value,
   output logic signed [sdstk_pkg::DATA_W-1:0]  pop_value,
   output logic [sdstk_pkg::STATUS_W-1:0]       status,
   output logic [sdstk_pkg::TOTAL_W-1:0]        total_length,
   output logic                                 all_empty
);

   localparam int CNT_W  = sdstk_pkg::CNT_W;
   localparam int ADDR_W = sdstk_pkg::ADDR_W;
   localparam int DATA_W = sdstk_pkg::DATA_W;

   // Captured item.
   logic [sdstk_pkg::FUNC_W-1:0] func_ff;
   logic                         sel_ff;
   logic [DATA_W-1:0]            value_ff;

   // Stack counts.
   logic [CNT_W-1:0] low_cnt_ff, low_cnt_in;
   logic [CNT_W-1:0] high_cnt_ff, high_cnt_in;

   // Outcome of the operation, held until the result is built.
   logic [sdstk_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                           pop_ok_ff, pop_ok_in;

   // Result register.
   logic [DATA_W-1:0]              rsp_value_ff;
   logic [sdstk_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [sdstk_pkg::TOTAL_W-1:0]  rsp_total_ff;
   logic                           rsp_empty_ff;

   // Memory port.
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] addr;
   logic [DATA_W-1:0] rd_data;

   // Address and count arithmetic.
   logic [CNT_W:0]   sum_cnt;
   logic             full;
   logic [CNT_W-1:0] low_dec, high_dec;
   logic [CNT_W-1:0] high_push_idx, high_pop_idx;
   logic [CNT_W-1:0] total;

   assign sum_cnt       = {1'b0, low_cnt_ff} + {1'b0, high_cnt_ff};
   assign full          = sum_cnt >= (CNT_W + 1)'(sdstk_pkg::DEPTH);
   assign low_dec       = low_cnt_ff - 1'b1;
   assign high_dec      = high_cnt_ff - 1'b1;
   assign high_push_idx = CNT_W'(sdstk_pkg::DEPTH - 1) - high_cnt_ff;
   assign high_pop_idx  = CNT_W'(sdstk_pkg::DEPTH) - high_cnt_ff;
   assign total         = low_cnt_ff + high_cnt_ff;

   // Capture the accepted item.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= func;
         sel_ff   <= stack_sel;
         value_ff <= push_value;
      end
   end

   // Carry out the operation: at most one memory access and the count update.
   always_comb begin
      low_cnt_in  = low_cnt_ff;
      high_cnt_in = high_cnt_ff;
      status_in   = status_ff;
      pop_ok_in   = pop_ok_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      addr        = '0;
      if (cmd.execute) begin
         status_in = sdstk_pkg::STATUS_OK;
         pop_ok_in = 1'b0;
         unique case (func_ff)
            sdstk_pkg::FUNC_PUSH: begin
               if (full) begin
                  status_in = sdstk_pkg::STATUS_FULL;
               end else if (!sel_ff) begin
                  wr_en      = 1'b1;
                  addr       = low_cnt_ff[ADDR_W-1:0];
                  low_cnt_in = low_cnt_ff + 1'b1;
               end else begin
                  wr_en       = 1'b1;
                  addr        = high_push_idx[ADDR_W-1:0];
                  high_cnt_in = high_cnt_ff + 1'b1;
               end
            end
            sdstk_pkg::FUNC_POP: begin
               if (!sel_ff) begin
                  if (low_cnt_ff == '0) begin
                     status_in = sdstk_pkg::STATUS_EMPTY;
                  end else begin
                     rd_en      = 1'b1;
                     pop_ok_in  = 1'b1;
                     addr       = low_dec[ADDR_W-1:0];
                     low_cnt_in = low_dec;
                  end
               end else begin
                  if (high_cnt_ff == '0) begin
                     status_in = sdstk_pkg::STATUS_EMPTY;
                  end else begin
                     rd_en       = 1'b1;
                     pop_ok_in   = 1'b1;
                     addr        = high_pop_idx[ADDR_W-1:0];
                     high_cnt_in = high_dec;
                  end
               end
            end
            sdstk_pkg::FUNC_CLEAR: begin
               low_cnt_in  = '0;
               high_cnt_in = '0;
            end
            default: begin
               // Unused code: nothing changes.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_cnt_ff  <= '0;
         high_cnt_ff <= '0;
      end else begin
         low_cnt_ff  <= low_cnt_in;
         high_cnt_ff <= high_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      pop_ok_ff <= pop_ok_in;
   end

   // Element storage shared by both stacks.
   sdstk_ram #(
      .WIDTH (DATA_W),
      .DEPTH (sdstk_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .rd_en   (rd_en),
      .addr    (addr),
      .wr_data (value_ff),
      .rd_data (rd_data)
   );

   // Build the result from the counts after the operation.
   always_ff @(posedge clock) begin
      if (cmd.deliver) begin
         rsp_value_ff  <= pop_ok_ff ? rd_data : '0;
         rsp_status_ff <= status_ff;
         rsp_total_ff  <= sdstk_pkg::TOTAL_W'(total);
         rsp_empty_ff  <= (total == '0);
      end
   end

   assign pop_value    = rsp_value_ff;
   assign status       = rsp_status_ff;
   assign total_length = rsp_total_ff;
   assign all_empty    = rsp_empty_ff;

endmodule

### src/sdstk_ctrl.sv
module sdstk_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sdstk_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // The result register can take a new item when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Sequencing of one item: capture, execute, load the result.
   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      cmd.deliver = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               cmd.deliver = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### tb/testbench.sv
module testbench;

   localparam int DEPTH    = sdstk_pkg::DEPTH;
   localparam int DATA_W   = sdstk_pkg::DATA_W;
   localparam int FUNC_W   = sdstk_pkg::FUNC_W;
   localparam int STATUS_W = sdstk_pkg::STATUS_W;
   localparam int TOTAL_W  = sdstk_pkg::TOTAL_W;

   // Operation code that the block ignores.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int IDLE_LIMIT     = 2000;
   localparam int PRESSURE_HOLD  = 150;
   localparam int RANDOM_ITEMS   = 980;

   typedef struct {
      logic signed [DATA_W-1:0] pop_value;
      logic [STATUS_W-1:0]      status;
      logic [TOTAL_W-1:0]       total_length;
      logic                     all_empty;
   } outcome_type;

   logic clock;
   logic reset;

   sdstk_req_if req_bus ();
   sdstk_rsp_if rsp_bus ();

   shared_double_stack uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Shadow copy of the two stacks.
   logic signed [DATA_W-1:0] element_copy [DEPTH];
   int low_count;
   int high_count;

   outcome_type pending_outcomes [$];
   int error_count;
   int stall_cycles;
   bit idle_on;
   int hold_cycles;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Counts a mismatch and reports only the first ten.
   function automatic void report_mismatch(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("mismatch: %s", msg);
      end
   endfunction

   // Applies one operation to the shadow stacks and returns the result it gives.
   function automatic outcome_type stack_outcome(input logic [FUNC_W-1:0] op, input logic sel,
                                                 input logic signed [DATA_W-1:0] value);
      outcome_type o;
      int total;
      o.pop_value = '0;
      o.status    = sdstk_pkg::STATUS_OK;
      case (op)
         sdstk_pkg::FUNC_PUSH: begin
            if (low_count + high_count >= DEPTH) begin
               o.status = sdstk_pkg::STATUS_FULL;
            end else if (!sel) begin
               element_copy[low_count] = value;
               low_count++;
            end else begin
               element_copy[DEPTH-1-high_count] = value;
               high_count++;
            end
         end
         sdstk_pkg::FUNC_POP: begin
            if (!sel) begin
               if (low_count == 0) begin
                  o.status = sdstk_pkg::STATUS_EMPTY;
               end else begin
                  low_count--;
                  o.pop_value = element_copy[low_count];
               end
            end else begin
               if (high_count == 0) begin
                  o.status = sdstk_pkg::STATUS_EMPTY;
               end else begin
                  high_count--;
                  o.pop_value = element_copy[DEPTH-1-high_count];
               end
            end
         end
         sdstk_pkg::FUNC_CLEAR: begin
            low_count  = 0;
            high_count = 0;
         end
         default: begin
         end
      endcase
      total          = low_count + high_count;
      o.total_length = total[TOTAL_W-1:0];
      o.all_empty    = (total == 0);
      return o;
   endfunction

   // Random element value, with the extremes drawn now and then.
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(7, 0))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Random stack select.
   function automatic logic pick_sel();
      return 1'($urandom_range(1, 0));
   endfunction

   // Offers one item, after a random gap when idle gaps are on, and records its expected result on acceptance.
   task automatic send_op(input logic [FUNC_W-1:0] op, input logic sel,
                          input logic signed [DATA_W-1:0] value);
      int gap;
      gap = idle_on ? $urandom_range(19, 0) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.func       <= op;
      req_bus.stack_sel  <= sel;
      req_bus.push_value <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pending_outcomes.push_back(stack_outcome(op, sel, value));
   endtask

   // Pops on an empty block, the ignored code and a clear.
   task automatic test_empty_stacks();
      send_op(sdstk_pkg::FUNC_POP, 1'b0, 32'sd5);
      send_op(sdstk_pkg::FUNC_POP, 1'b1, -32'sd5);
      send_op(FUNC_UNUSED, 1'b1, 32'sh7fff_ffff);
      send_op(sdstk_pkg::FUNC_CLEAR, 1'b0, 32'sh8000_0000);
   endtask

   // Extreme values through both stacks, read back in LIFO order.
   task automatic test_extreme_values();
      send_op(sdstk_pkg::FUNC_PUSH, 1'b0, 32'sh8000_0000);
      send_op(sdstk_pkg::FUNC_PUSH, 1'b1, 32'sh7fff_ffff);
      send_op(sdstk_pkg::FUNC_PUSH, 1'b0, 32'sd0);
      send_op(sdstk_pkg::FUNC_PUSH, 1'b1, -32'sd1);
      send_op(sdstk_pkg::FUNC_PUSH, 1'b0, 32'sh5555_aaaa);
      send_op(FUNC_UNUSED, 1'b0, 32'sd0);
      send_op(sdstk_pkg::FUNC_POP, 1'b0, 32'sd0);
      send_op(sdstk_pkg::FUNC_POP, 1'b1, 32'sd0);
      send_op(sdstk_pkg::FUNC_POP, 1'b0, 32'sd0);
      send_op(sdstk_pkg::FUNC_POP, 1'b1, 32'sd0);
      send_op(sdstk_pkg::FUNC_POP, 1'b1, 32'sd0);
      send_op(sdstk_pkg::FUNC_POP, 1'b0, 32'sd0);
      send_op(sdstk_pkg::FUNC_PUSH, 1'b1, 32'sh1234_5678);
      send_op(sdstk_pkg::FUNC_CLEAR, 1'b1, 32'sd0);
      send_op(sdstk_pkg::FUNC_POP, 1'b1, 32'sd0);
   endtask

   // Fills the shared memory, pushes into the full block, then pops from both sides and clears.
   task automatic test_fill_to_capacity();
      repeat (DEPTH) send_op(sdstk_pkg::FUNC_PUSH, pick_sel(), pick_value());
      send_op(sdstk_pkg::FUNC_PUSH, 1'b0, pick_value());
      send_op(sdstk_pkg::FUNC_PUSH, 1'b1, pick_value());
      repeat (DEPTH / 2 + 2) send_op(sdstk_pkg::FUNC_POP, 1'b0, pick_value());
      repeat (DEPTH / 2 + 2) send_op(sdstk_pkg::FUNC_POP, 1'b1, pick_value());
      send_op(sdstk_pkg::FUNC_CLEAR, 1'b0, 32'sd0);
   endtask

   // The receiver holds off for a long stretch while items keep coming.
   task automatic test_backpressure();
      logic [FUNC_W-1:0] op;
      idle_on     = 1'b0;
      hold_cycles = PRESSURE_HOLD;
      repeat (40) begin
         op = ($urandom_range(1, 0) == 0) ? sdstk_pkg::FUNC_PUSH : sdstk_pkg::FUNC_POP;
         send_op(op, pick_sel(), pick_value());
      end
   endtask

   // Runs of push-heavy, pop-heavy and mixed traffic with occasional clears and ignored codes.
   task automatic test_random_traffic(input int item_goal);
      int sent;
      int push_share;
      int roll;
      int run_len;
      logic [FUNC_W-1:0] op;
      sent = 0;
      while (sent < item_goal) begin
         case ($urandom_range(2, 0))
            0: push_share = 85;
            1: push_share = 20;
            default: push_share = 52;
         endcase
         idle_on = ($urandom_range(3, 0) != 0);
         run_len = $urandom_range(60, 10);
         repeat (run_len) begin
            roll = $urandom_range(99, 0);
            if (roll < 2) begin
               op = sdstk_pkg::FUNC_CLEAR;
            end else if (roll < 4) begin
               op = FUNC_UNUSED;
            end else if (roll < push_share) begin
               op = sdstk_pkg::FUNC_PUSH;
            end else begin
               op = sdstk_pkg::FUNC_POP;
            end
            send_op(op, pick_sel(), pick_value());
            if (op != FUNC_UNUSED) sent++;
         end
      end
   endtask

   // Receiver: random ready gaps, optional long hold, and field checks.
   initial begin
      int gap;
      outcome_type want;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         gap = idle_on ? $urandom_range(19, 0) : 0;
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         if (pending_outcomes.size() == 0) begin
            report_mismatch("result item with no operation waiting");
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_bus.pop_value !== want.pop_value)
               report_mismatch($sformatf("pop_value expected %0d, got %0d",
                                         want.pop_value, rsp_bus.pop_value));
            if (rsp_bus.status !== want.status)
               report_mismatch($sformatf("status expected %0d, got %0d",
                                         want.status, rsp_bus.status));
            if (rsp_bus.total_length !== want.total_length)
               report_mismatch($sformatf("total_length expected %0d, got %0d",
                                         want.total_length, rsp_bus.total_length));
            if (rsp_bus.all_empty !== want.all_empty)
               report_mismatch($sformatf("all_empty expected %0d, got %0d",
                                         want.all_empty, rsp_bus.all_empty));
         end
      end
   end

   // Watchdog: ends the run when no item moves for too long.
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Reset, the test sequence and the final verdict.
   initial begin
      error_count  = 0;
      stall_cycles = 0;
      low_count    = 0;
      high_count   = 0;
      hold_cycles  = 0;
      idle_on      = 1'b1;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.func       <= sdstk_pkg::FUNC_PUSH;
      req_bus.stack_sel  <= 1'b0;
      req_bus.push_value <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_stacks();
      test_extreme_values();
      idle_on = 1'b1;
      test_fill_to_capacity();
      test_backpressure();
      test_random_traffic(RANDOM_ITEMS);

      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
